// ===== hdl/rpn_pkg.sv =====
package rpn_pkg;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int DEPTH_W = 7;
    localparam int STAT_W  = 3;

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_UNDER = 3'd1;
    localparam logic [STAT_W-1:0] STAT_OVER  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DIVZ  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_SAT   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_ALU  = 4'b0100,
        S_DONE = 4'b1000
    } ctl_state_t;

    typedef enum logic [4:0] {
        AS_IDLE = 5'b00001,
        AS_EXEC = 5'b00010,
        AS_MUL  = 5'b00100,
        AS_DIV  = 5'b01000,
        AS_DFIN = 5'b10000
    } alu_state_t;

    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic sat;
        logic divz;
    } alu_rsp_t;

endpackage

// ===== hdl/rpn_ram.sv =====
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rpn_alu.sv =====
module rpn_alu import rpn_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  alu_req_t          req,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output alu_rsp_t          rsp,
    output logic [DATA_W-1:0] result
);

    localparam int NUM_W  = DATA_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int PROD_W = 2 * DATA_W;

    alu_state_t          state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic                neg_reg, neg_next;
    logic [DATA_W-1:0]   mag_a_reg, mag_a_next;
    logic [DATA_W-1:0]   mag_b_reg, mag_b_next;
    logic [DATA_W:0]     sum_reg, sum_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DATA_W-1:0]   result_reg, result_next;
    logic                done_reg, done_next;
    logic                sat_reg, sat_next;
    logic                divz_reg, divz_next;

    logic [DATA_W:0]     rem_sh;
    logic [DATA_W:0]     diff;
    logic [DATA_W:0]     clamped;

    // {saturated, value} of a sign and magnitude clamped to 32 bits
    function automatic logic [DATA_W:0] clamp_mag(input logic neg, input logic [PROD_W-1:0] mag);
        logic [DATA_W:0] r;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                r = {1'b1, 32'h8000_0000};
            end else begin
                r = {1'b0, 32'd0 - mag[DATA_W-1:0]};
            end
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                r = {1'b1, 32'h7FFF_FFFF};
            end else begin
                r = {1'b0, mag[DATA_W-1:0]};
            end
        end
        return r;
    endfunction

    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, mag_b_reg};

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        neg_next    = neg_reg;
        mag_a_next  = mag_a_reg;
        mag_b_next  = mag_b_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        sat_next    = sat_reg;
        divz_next   = divz_reg;
        clamped     = '0;

        unique case (state_reg)
            AS_IDLE: begin
                if (req.start) begin
                    op_next    = req.op;
                    neg_next   = a[DATA_W-1] ^ b[DATA_W-1];
                    mag_a_next = a[DATA_W-1] ? 32'd0 - a : a;
                    mag_b_next = b[DATA_W-1] ? 32'd0 - b : b;
                    if (req.op == OP_SUB) begin
                        sum_next = {a[DATA_W-1], a} - {b[DATA_W-1], b};
                    end else begin
                        sum_next = {a[DATA_W-1], a} + {b[DATA_W-1], b};
                    end
                    state_next = AS_EXEC;
                end
            end
            AS_EXEC: begin
                case (op_reg)
                    OP_ADD, OP_SUB: begin
                        divz_next = 1'b0;
                        if (sum_reg[DATA_W] != sum_reg[DATA_W-1]) begin
                            sat_next    = 1'b1;
                            result_next = sum_reg[DATA_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        end else begin
                            sat_next    = 1'b0;
                            result_next = sum_reg[DATA_W-1:0];
                        end
                        done_next  = 1'b1;
                        state_next = AS_IDLE;
                    end
                    OP_MUL: begin
                        prod_next  = PROD_W'(mag_a_reg) * PROD_W'(mag_b_reg);
                        state_next = AS_MUL;
                    end
                    OP_DIV: begin
                        if (mag_b_reg == '0) begin
                            divz_next  = 1'b1;
                            sat_next   = 1'b0;
                            done_next  = 1'b1;
                            state_next = AS_IDLE;
                        end else begin
                            num_next   = NUM_W'(mag_a_reg) << FRAC_BITS;
                            rem_next   = '0;
                            cnt_next   = '0;
                            state_next = AS_DIV;
                        end
                    end
                    default: begin
                        divz_next   = 1'b0;
                        sat_next    = 1'b0;
                        result_next = '0;
                        done_next   = 1'b1;
                        state_next  = AS_IDLE;
                    end
                endcase
            end
            AS_MUL: begin
                clamped     = clamp_mag(neg_reg, prod_reg >> FRAC_BITS);
                sat_next    = clamped[DATA_W];
                divz_next   = 1'b0;
                result_next = clamped[DATA_W-1:0];
                done_next   = 1'b1;
                state_next  = AS_IDLE;
            end
            AS_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (!diff[DATA_W]) begin
                    rem_next = diff[DATA_W-1:0];
                    num_next = {num_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[DATA_W-1:0];
                    num_next = {num_reg[NUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = AS_DFIN;
                end
            end
            AS_DFIN: begin
                clamped     = clamp_mag(neg_reg, PROD_W'(num_reg));
                sat_next    = clamped[DATA_W];
                divz_next   = 1'b0;
                result_next = clamped[DATA_W-1:0];
                done_next   = 1'b1;
                state_next  = AS_IDLE;
            end
            default: begin
                state_next = AS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        neg_reg    <= neg_next;
        mag_a_reg  <= mag_a_next;
        mag_b_reg  <= mag_b_next;
        sum_reg    <= sum_next;
        prod_reg   <= prod_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
        sat_reg    <= sat_next;
        divz_reg   <= divz_next;
    end

    assign rsp    = '{done: done_reg, sat: sat_reg, divz: divz_reg};
    assign result = result_reg;

endmodule

// ===== hdl/rpn_stack_evaluator_top.sv =====
// Reverse Polish evaluator over signed fixed-point numbers (FRAC_BITS fraction bits).
// Input channel s_*: one request per token. s_tuser is the op (push, add, subtract,
// multiply, divide), s_tdata the value to push, s_tlast marks the end of an expression.
// Result channel m_*: one request per token with the new top of stack (0 when empty),
// the depth, a status in m_tuser and s_tlast echoed on m_tlast.
// The stack lives in a one-read, one-write RAM; the top entry is also kept in a
// register, so an operator reads only the entry below it.
// A divide runs a bit-serial quotient loop, one bit per cycle over 32 + FRAC_BITS
// bits. A push, an operator on fewer than two entries and an unused op code skip
// the RAM read and the ALU; a divide by zero still passes through the ALU.
// The result appears in the same cycle that s_tready returns high.
// Tokens are taken one at a time; s_tready is high only between tokens.
// The result sits in an output register; a new token is accepted while it waits,
// and that token's result holds off until the receiver takes the previous one.
// Reset empties the stack (depth 0) and drops any pending result; RAM contents are
// not cleared and entries are only read after being pushed.
module rpn_stack_evaluator_top import rpn_pkg::*; #(
    parameter int STACK_DEPTH = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [OP_W-1:0]   s_tuser,   // [2:0] op
    input  logic              s_tlast,   // last_token
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // [31:0] top_value, [38:32] depth, [39] zero
    output logic [STAT_W-1:0] m_tuser,   // [2:0] status
    output logic              m_tlast    // final_res
);

    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    ctl_state_t          state_reg, state_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic [DATA_W-1:0]   top_reg, top_next;
    logic [OP_W-1:0]     tok_op_reg, tok_op_next;
    logic [DATA_W-1:0]   tok_val_reg, tok_val_next;
    logic                tok_last_reg, tok_last_next;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_top_reg, m_top_next;
    logic [DEPTH_W-1:0]  m_depth_reg, m_depth_next;
    logic [STAT_W-1:0]   m_status_reg, m_status_next;
    logic                m_last_reg, m_last_next;

    logic                out_free;
    logic                in_is_oper;
    logic                tok_is_oper;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   below_addr;
    logic [DATA_W-1:0]   ram_rdata;
    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;
    logic [DATA_W-1:0]   alu_result;

    assign out_free    = !m_valid_reg || m_tready;
    assign in_is_oper  = (s_tuser == OP_ADD) || (s_tuser == OP_SUB) ||
                         (s_tuser == OP_MUL) || (s_tuser == OP_DIV);
    assign tok_is_oper = (tok_op_reg == OP_ADD) || (tok_op_reg == OP_SUB) ||
                         (tok_op_reg == OP_MUL) || (tok_op_reg == OP_DIV);
    assign below_addr  = ADDR_W'(sp_reg - SP_W'(2));

    always_comb begin
        state_next    = state_reg;
        sp_next       = sp_reg;
        top_next      = top_reg;
        tok_op_next   = tok_op_reg;
        tok_val_next  = tok_val_reg;
        tok_last_next = tok_last_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_top_next    = m_top_reg;
        m_depth_next  = m_depth_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        ram_we        = 1'b0;
        ram_waddr     = below_addr;
        ram_wdata     = alu_result;
        ram_re        = 1'b0;
        alu_req       = '{start: 1'b0, op: tok_op_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    tok_op_next   = s_tuser;
                    tok_val_next  = s_tdata;
                    tok_last_next = s_tlast;
                    if (in_is_oper && sp_reg >= SP_W'(2)) begin
                        ram_re     = 1'b1;
                        state_next = S_READ;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_READ: begin
                alu_req.start = 1'b1;
                state_next    = S_ALU;
            end
            S_ALU: begin
                if (alu_rsp.done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_status_next = STAT_OK;
                    if (tok_op_reg == OP_PUSH) begin
                        if (sp_reg == SP_W'(STACK_DEPTH)) begin
                            m_status_next = STAT_OVER;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = sp_reg[ADDR_W-1:0];
                            ram_wdata = tok_val_reg;
                            top_next  = tok_val_reg;
                            sp_next   = sp_reg + 1'b1;
                        end
                    end else if (tok_is_oper) begin
                        if (sp_reg < SP_W'(2)) begin
                            m_status_next = STAT_UNDER;
                        end else if (alu_rsp.divz) begin
                            m_status_next = STAT_DIVZ;
                        end else begin
                            ram_we        = 1'b1;
                            top_next      = alu_result;
                            sp_next       = sp_reg - 1'b1;
                            m_status_next = alu_rsp.sat ? STAT_SAT : STAT_OK;
                        end
                    end
                    m_valid_next = 1'b1;
                    m_top_next   = (sp_next == '0) ? '0 : top_next;
                    m_depth_next = DEPTH_W'(sp_next);
                    m_last_next  = tok_last_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        tok_op_reg   <= tok_op_next;
        tok_val_reg  <= tok_val_next;
        tok_last_reg <= tok_last_next;
        m_top_reg    <= m_top_next;
        m_depth_reg  <= m_depth_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (below_addr),
        .rdata (ram_rdata)
    );

    rpn_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (ram_rdata),
        .b       (top_reg),
        .rsp     (alu_rsp),
        .result  (alu_result)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_depth_reg, m_top_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule
